/* rtl/core/rounded_mul_div_saturating_macros.svh */
// Assertion macros for the rounded multiply-divide checker.
`ifndef ROUNDED_MUL_DIV_SATURATING_MACROS_SVH
`define ROUNDED_MUL_DIV_SATURATING_MACROS_SVH

// consequent holds in the cycle after reset
`define RMDS_ASSERT_AFTER_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) (reset) |=> (cons)) else $error(msg);

// same-cycle implication, ignored while in reset
`define RMDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while in reset
`define RMDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rmds_pkg.sv */
// Shared types and constants for the rounded multiply-divide block.
package rmds_pkg;

   localparam int WORD_W       = 16;
   localparam int PROD_W       = 2 * WORD_W;
   localparam int DIVD_W       = PROD_W + 1;
   localparam int DIV_STAGES   = WORD_W;
   localparam int RMDS_MID_DEPTH = 4;
   localparam int RMDS_OUT_DEPTH = 4;

   localparam logic [WORD_W-1:0] SIGNED_MAX_MAG = 16'h7fff;
   localparam logic [WORD_W-1:0] UNSIGNED_MAX   = 16'hffff;

   typedef enum logic {
      MODE_SIGNED   = 1'b0,
      MODE_UNSIGNED = 1'b1
   } rmds_mode_type;

   // classified operands handed from front to back
   typedef struct packed {
      logic              signed_op;
      logic              neg;
      logic [WORD_W-1:0] vm;
      logic [WORD_W-1:0] nm;
      logic [WORD_W-1:0] dm;
   } rmds_class_type;

   typedef struct packed {
      logic              signed_op;
      logic              neg;
      logic [WORD_W-1:0] dm;
      logic [PROD_W-1:0] prod;
   } rmds_prod_type;

   typedef struct packed {
      logic              signed_op;
      logic              neg;
      logic              ovf;
      logic [WORD_W-1:0] dm;
      logic [WORD_W-1:0] rem;
      logic [WORD_W-1:0] low;
   } rmds_div_type;

endpackage

/* rtl/core/rmds_queue.sv */
// Small register queue, combinational read of the oldest entry.
module rmds_queue #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] mem_in [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      mem_in = mem_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_data;
      end
      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/rmds_front.sv */
// Front end: accepts transactions, takes magnitudes and works out the result sign.
module rmds_front
   import rmds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_mode,
   input  logic [WORD_W-1:0] req_value,
   input  logic [WORD_W-1:0] req_numerator,
   input  logic [WORD_W-1:0] req_denominator,
   output logic              cls_push,
   output rmds_class_type    cls_data,
   input  logic              cls_full
);

   logic           valid_ff, valid_in;
   rmds_class_type data_ff, data_in;
   rmds_class_type cls;
   logic           accept;
   logic           prod_neg;

   assign req_full = valid_ff && cls_full;
   assign accept   = req_push && !req_full;
   assign cls_push = valid_ff;
   assign cls_data = data_ff;

   always_comb begin
      cls.signed_op = (rmds_mode_type'(req_mode) == MODE_SIGNED);
      cls.vm = (cls.signed_op && req_value[WORD_W-1])
               ? WORD_W'(~req_value + 1'b1) : req_value;
      cls.nm = (cls.signed_op && req_numerator[WORD_W-1])
               ? WORD_W'(~req_numerator + 1'b1) : req_numerator;
      cls.dm = (cls.signed_op && req_denominator[WORD_W-1])
               ? WORD_W'(~req_denominator + 1'b1) : req_denominator;
      prod_neg = (req_value != '0) && (req_numerator != '0)
                 && (req_value[WORD_W-1] ^ req_numerator[WORD_W-1]);
      cls.neg = cls.signed_op && (prod_neg ^ req_denominator[WORD_W-1]);

      valid_in = accept || (valid_ff && cls_full);
      data_in  = accept ? cls : data_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

/* rtl/core/rmds_back.sv */
// Back end: product stage, one-bit-per-stage restoring divider, saturation.
module rmds_back
   import rmds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rmds_class_type    in_data,
   output logic              in_pop,
   output logic              out_push,
   output logic [WORD_W-1:0] out_word,
   input  logic              out_full
);

   logic                   prod_valid_ff, prod_valid_in;
   rmds_prod_type          prod_ff, prod_in;
   logic [DIV_STAGES:0]    div_valid_ff, div_valid_in;
   rmds_div_type           div_ff [DIV_STAGES+1];
   rmds_div_type           div_in [DIV_STAGES+1];
   logic                   advance;
   logic [DIVD_W-1:0]      dividend;
   logic [WORD_W:0]        div_hi;
   rmds_div_type           last;
   logic [WORD_W-1:0]      mag;

   function automatic rmds_div_type div_step(rmds_div_type s);
      rmds_div_type    r;
      logic [WORD_W:0] t;
      t = {s.rem, s.low[WORD_W-1]};
      r = s;
      if (t >= {1'b0, s.dm}) begin
         r.rem = WORD_W'(t - {1'b0, s.dm});
         r.low = {s.low[WORD_W-2:0], 1'b1};
      end else begin
         r.rem = t[WORD_W-1:0];
         r.low = {s.low[WORD_W-2:0], 1'b0};
      end
      return r;
   endfunction

   assign advance  = !div_valid_ff[DIV_STAGES] || !out_full;
   assign in_pop   = in_valid && advance;
   assign out_push = div_valid_ff[DIV_STAGES] && !out_full;
   assign last     = div_ff[DIV_STAGES];

   always_comb begin
      prod_in.signed_op = in_data.signed_op;
      prod_in.neg       = in_data.neg;
      prod_in.dm        = in_data.dm;
      prod_in.prod      = in_data.vm * in_data.nm;
      prod_valid_in     = advance ? in_valid : prod_valid_ff;

      // rounding bias; quotient overflows when the top half reaches the divisor
      dividend = {1'b0, prod_ff.prod} + DIVD_W'(prod_ff.dm >> 1);
      div_hi   = dividend[DIVD_W-1:WORD_W];
      div_in[0].signed_op = prod_ff.signed_op;
      div_in[0].neg       = prod_ff.neg;
      div_in[0].dm        = prod_ff.dm;
      div_in[0].ovf       = (div_hi >= {1'b0, prod_ff.dm});
      div_in[0].rem       = div_hi[WORD_W-1:0];
      div_in[0].low       = dividend[WORD_W-1:0];
      div_valid_in[0]     = advance ? prod_valid_ff : div_valid_ff[0];

      for (int k = 1; k <= DIV_STAGES; k++) begin
         div_in[k]       = div_step(div_ff[k-1]);
         div_valid_in[k] = advance ? div_valid_ff[k-1] : div_valid_ff[k];
      end

      if (last.signed_op) begin
         mag = (last.ovf || last.low[WORD_W-1]) ? SIGNED_MAX_MAG : last.low;
      end else begin
         mag = last.ovf ? UNSIGNED_MAX : last.low;
      end
      out_word = last.neg ? WORD_W'(~mag + 1'b1) : mag;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         div_ff  <= div_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         div_valid_ff  <= '0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         div_valid_ff  <= div_valid_in;
      end
   end

endmodule

/* rtl/core/rounded_mul_div_saturating.sv */
// Top level of the rounded, saturating 16-bit multiply-divide block.
// Request side is a queue input: present req_mode, req_value, req_numerator
// and req_denominator with req_push; the transaction is taken on a clock edge
// where req_push is high and req_full is low.
// Response side is a queue output: while rsp_empty is low the oldest result
// sits on rsp_quotient_word; it is taken on an edge with rsp_pop high.
// Each request gives exactly one response, in request order.
// Path from request to response: front register, mid queue, product stage,
// rounding stage and a 16-stage restoring divider (one quotient bit per stage),
// then the response queue.
// Throughput: one transaction per cycle unless stalled; every stage is a
// pipeline register. When the receiver stalls, results collect in the
// response queue; once it is full the divider pipeline holds, the mid queue
// fills and req_full rises. Reset (synchronous, active high) empties both
// queues and all pipeline valids; no request is held over.
module rounded_mul_div_saturating
   import rmds_pkg::*;
#(
   parameter int MID_DEPTH = RMDS_MID_DEPTH,
   parameter int OUT_DEPTH = RMDS_OUT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_mode,
   input  logic [WORD_W-1:0] req_value,
   input  logic [WORD_W-1:0] req_numerator,
   input  logic [WORD_W-1:0] req_denominator,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [WORD_W-1:0] rsp_quotient_word
);

   localparam int CLS_W = $bits(rmds_class_type);

   logic              cls_push, cls_full, mid_empty, mid_pop;
   rmds_class_type    cls_data, mid_data;
   logic [CLS_W-1:0]  mid_bits;
   logic              out_push, out_full;
   logic [WORD_W-1:0] out_word;

   assign mid_data = rmds_class_type'(mid_bits);

   rmds_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_numerator   (req_numerator),
      .req_denominator (req_denominator),
      .cls_push        (cls_push),
      .cls_data        (cls_data),
      .cls_full        (cls_full)
   );

   rmds_queue #(
      .WIDTH (CLS_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_push),
      .push_data (CLS_W'(cls_data)),
      .full      (cls_full),
      .pop       (mid_pop),
      .pop_data  (mid_bits),
      .empty     (mid_empty)
   );

   rmds_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (!mid_empty),
      .in_data  (mid_data),
      .in_pop   (mid_pop),
      .out_push (out_push),
      .out_word (out_word),
      .out_full (out_full)
   );

   rmds_queue #(
      .WIDTH (WORD_W),
      .DEPTH (OUT_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_word),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_quotient_word),
      .empty     (rsp_empty)
   );

endmodule

/* rtl/core/rmds_checker.sv */
// Port-level assertions for the rounded multiply-divide block, with bind.
`include "rounded_mul_div_saturating_macros.svh"

module rmds_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        req_mode,
   input logic [15:0] req_value,
   input logic [15:0] req_numerator,
   input logic [15:0] req_denominator,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_quotient_word
);

   `RMDS_ASSERT_AFTER_RESET(a_reset_clears, rsp_empty && !req_full, "reset did not clear queues")

   `RMDS_ASSERT_AFTER_RESET(a_no_early_rsp, rsp_empty ##1 rsp_empty ##1 rsp_empty,
      "response too soon after reset")

   `RMDS_ASSERT_NOW(a_full_needs_backlog, req_full, !rsp_empty,
      "request side full with no response waiting")

   `RMDS_ASSERT_NEXT(a_rsp_holds, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_quotient_word), "waiting response changed")

endmodule

bind rounded_mul_div_saturating rmds_checker u_checker (.*);

/* verif/rounded_mul_div_saturating_tb.sv */
// Self-checking testbench for the rounded, saturating 16-bit multiply-divide block.
module rounded_mul_div_saturating_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rmds_pkg::*;

   localparam int RANDOM_ITEMS = 2000;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD    = 300;

   localparam logic [WORD_W-1:0] CORNER_WORDS [8] = '{
      16'h0000, 16'h0001, 16'h0002, 16'h7ffe, 16'h7fff, 16'h8000, 16'h8001, 16'hffff
   };

   typedef struct packed {
      rmds_mode_type     mode;
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] numerator;
      logic [WORD_W-1:0] denominator;
      logic              typed;
      logic [WORD_W-1:0] want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 21;

   // typed rows: zero divisor, saturation at both extremes, reset-fresh pass
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{MODE_SIGNED,   16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7fff},
      '{MODE_SIGNED,   16'hffff, 16'h0001, 16'h0000, 1'b1, 16'h8001},
      '{MODE_UNSIGNED, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'hffff},
      '{MODE_UNSIGNED, 16'hffff, 16'hffff, 16'h0001, 1'b1, 16'hffff},
      '{MODE_SIGNED,   16'h7fff, 16'h7fff, 16'h0001, 1'b1, 16'h7fff},
      '{MODE_SIGNED,   16'h8000, 16'h7fff, 16'h0001, 1'b1, 16'h8001},
      '{MODE_SIGNED,   16'h8000, 16'h8000, 16'h0001, 1'b1, 16'h7fff},
      '{MODE_UNSIGNED, 16'h0001, 16'h0001, 16'h0001, 1'b1, 16'h0001},
      '{MODE_SIGNED,   16'h0003, 16'h0001, 16'h0002, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'hfffd, 16'h0001, 16'h0002, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h0001, 16'h0001, 16'h8000, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h0000, 16'h0005, 16'hffff, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h0006, 16'h0001, 16'hfffe, 1'b0, 16'h0000},
      '{MODE_UNSIGNED, 16'h0005, 16'h0001, 16'h0002, 1'b0, 16'h0000},
      '{MODE_UNSIGNED, 16'h0001, 16'h0001, 16'hffff, 1'b0, 16'h0000},
      '{MODE_UNSIGNED, 16'h8000, 16'h0002, 16'h0001, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h8000, 16'h0001, 16'hffff, 1'b0, 16'h0000},
      '{MODE_UNSIGNED, 16'hffff, 16'hffff, 16'hffff, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h7fff, 16'hffff, 16'h8000, 1'b0, 16'h0000},
      '{MODE_UNSIGNED, 16'h0001, 16'hffff, 16'h0002, 1'b0, 16'h0000},
      '{MODE_SIGNED,   16'h0005, 16'h0003, 16'h0004, 1'b0, 16'h0000}
   };

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_mode;
   logic [WORD_W-1:0] req_value;
   logic [WORD_W-1:0] req_numerator;
   logic [WORD_W-1:0] req_denominator;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [WORD_W-1:0] rsp_quotient_word;

   logic              drv_typed;
   logic [WORD_W-1:0] drv_want;
   logic              long_hold_req;

   logic [WORD_W-1:0] quotient_due [$];
   int                mismatches;

   rounded_mul_div_saturating dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_numerator     (req_numerator),
      .req_denominator   (req_denominator),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_quotient_word (rsp_quotient_word)
   );

   function automatic logic [WORD_W-1:0] round_mul_div(rmds_mode_type m,
         logic [WORD_W-1:0] v, logic [WORD_W-1:0] n, logic [WORD_W-1:0] d);
      logic [16:0] vm, nm, dm;
      logic        neg;
      logic [33:0] prod;
      logic [33:0] q;
      if (m == MODE_UNSIGNED) begin
         if (d == '0) begin
            q = 34'(UNSIGNED_MAX);
         end else begin
            prod = 34'(v) * 34'(n);
            q = (prod + 34'(d >> 1)) / 34'(d);
            if (q > 34'(UNSIGNED_MAX)) begin
               q = 34'(UNSIGNED_MAX);
            end
         end
         return q[WORD_W-1:0];
      end
      vm = v[15] ? 17'h10000 - 17'(v) : 17'(v);
      nm = n[15] ? 17'h10000 - 17'(n) : 17'(n);
      dm = d[15] ? 17'h10000 - 17'(d) : 17'(d);
      prod = 34'(vm) * 34'(nm);
      neg = ((prod != '0) && (v[15] != n[15])) != d[15];
      if (dm == '0) begin
         q = 34'(SIGNED_MAX_MAG);
      end else begin
         q = (prod + 34'(dm >> 1)) / 34'(dm);
      end
      if (q > 34'(SIGNED_MAX_MAG)) begin
         q = 34'(SIGNED_MAX_MAG);
      end
      return neg ? 16'(17'h10000 - q[16:0]) : q[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 9))
         4: w = 16'($urandom_range(0, 15));
         5: w = -16'($urandom_range(1, 16));
         6: w = 16'($urandom_range(0, 255));
         7: w = 16'h0001 << $urandom_range(0, 15);
         8: w = CORNER_WORDS[$urandom_range(0, 7)];
         9: w = 16'($urandom_range(0, 16'h7fff)) >> $urandom_range(0, 14);
         default: w = 16'($urandom);
      endcase
      return w;
   endfunction

   task automatic offer(input rmds_mode_type m, input logic [WORD_W-1:0] v,
         input logic [WORD_W-1:0] n, input logic [WORD_W-1:0] d,
         input logic typed, input logic [WORD_W-1:0] want);
      @(negedge clock);
      req_push        = 1'b1;
      req_mode        = m;
      req_value       = v;
      req_numerator   = n;
      req_denominator = d;
      drv_typed       = typed;
      drv_want        = want;
      do @(posedge clock); while (req_full);
   endtask

   task automatic rest(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_push = 1'b0;
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (quotient_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result check, then capture of the accepted request transaction
   always @(posedge clock) begin : scoreboard
      logic [WORD_W-1:0] want;
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (quotient_due.size() == 0) begin
               $display("%0t: result %h with no transaction outstanding",
                        $time, rsp_quotient_word);
               mismatches++;
            end else begin
               want = quotient_due.pop_front();
               if (rsp_quotient_word !== want) begin
                  $display("%0t: quotient_word expected %h actual %h",
                           $time, want, rsp_quotient_word);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full) begin
            quotient_due.push_back(drv_typed ? drv_want :
               round_mul_div(rmds_mode_type'(req_mode), req_value, req_numerator,
                             req_denominator));
         end
      end
   end

   initial begin : receiver
      int pop_style;
      int style_left;
      int hold_left;
      int phase;
      pop_style  = 0;
      style_left = 0;
      hold_left  = 0;
      phase      = 0;
      rsp_pop    = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_pop = 1'b0;
            hold_left--;
         end else begin
            if (style_left == 0) begin
               pop_style  = $urandom_range(0, 3);
               style_left = $urandom_range(20, 200);
            end
            style_left--;
            phase++;
            case (pop_style)
               0: rsp_pop = 1'b1;
               1: rsp_pop = 1'($urandom_range(0, 1));
               2: rsp_pop = ($urandom_range(0, 3) == 0);
               default: rsp_pop = (phase % 3 != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int burst_left;
      rmds_mode_type m;
      logic [WORD_W-1:0] d;
      reset           = 1'b1;
      req_push        = 1'b0;
      req_mode        = 1'b0;
      req_value       = '0;
      req_numerator   = '0;
      req_denominator = '0;
      drv_typed       = 1'b0;
      drv_want        = '0;
      long_hold_req   = 1'b0;
      mismatches      = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[i]) begin
         offer(DIRECTED[i].mode, DIRECTED[i].value, DIRECTED[i].numerator,
               DIRECTED[i].denominator, DIRECTED[i].typed, DIRECTED[i].want);
         if ($urandom_range(0, 2) == 0) begin
            rest($urandom_range(1, 3));
         end
      end
      settle();

      // receiver holds off while a long gap-free burst backs the block up
      long_hold_req = 1'b1;
      burst_left = 80;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            rest($urandom_range(1, 12));
            burst_left = $urandom_range(1, 50);
         end
         if (i == RANDOM_ITEMS / 2) begin
            settle();
         end
         m = rmds_mode_type'($urandom_range(0, 1));
         d = ($urandom_range(0, 11) == 0) ? '0 : pick_word();
         offer(m, pick_word(), pick_word(), d, 1'b0, '0);
         burst_left--;
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* rounded_mul_div_saturating.f */
+incdir+rtl/core
rtl/core/rmds_pkg.sv
rtl/core/rmds_queue.sv
rtl/core/rmds_front.sv
rtl/core/rmds_back.sv
rtl/core/rounded_mul_div_saturating.sv
rtl/core/rmds_checker.sv
verif/rounded_mul_div_saturating_tb.sv
